// ===== rtl/tcsq_pkg.sv =====
// ============================================================================
// tcsq_pkg : shared types for the timed command scheduler queue
// Entry, request, response and cell control types used by the queue cells
// and the top level.
// ============================================================================
`default_nettype none

package tcsq_pkg;

  // Operation codes carried in the request word.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // What every cell of the chain does with its entry.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] value;
    logic [31:0] due;
    logic [31:0] interval;
  } entry_t;

  // Broadcast to all cells: the operation, whether a pop also places a
  // re-armed copy, and the entry to be placed.
  typedef struct packed {
    cell_op_e op;
    logic     rearm;
    entry_t   fresh;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_time;
    logic [7:0]  command_code;
    logic [31:0] command_value;
    logic [31:0] due_time;
    logic [31:0] repeat_interval;
  } req_t;

  typedef struct packed {
    logic        due_valid;
    logic [7:0]  due_command;
    logic [31:0] due_value;
    logic        insert_accepted;
    logic        rearm_dropped;
    logic [4:0]  entries_held;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/timed_command_scheduler_queue.sv =====
// ============================================================================
// timed_command_scheduler_queue : time-ordered command queue
// Sorted shift-register queue of scheduled commands with periodic re-arm.
// ============================================================================
//
// A request word is taken at a rising edge where start_i is high and busy_o
// is low. Its cmd field selects a tick (release the head entry when it is
// due), an insert (place a command before the first entry that is strictly
// later, so equal due times keep arrival order) or a clear.
// Every request word gives exactly one response word on rsp_o, marked by
// done_o for one cycle, in the cycle after the request was taken. The
// receiver cannot hold responses off, and none is needed: busy_o stays
// low, so the queue takes a new request word in every cycle.
// The queue is a row of QUEUE_DEPTH identical cells. Each cell compares its
// own due time against the broadcast entry and shifts left, shifts right,
// holds or loads the new entry, so an insert, or a tick that removes the
// head and re-arms a periodic copy at due time plus interval, is carried
// out by all cells together. The head compare, the re-arm add and the
// cell compare form the longest path.
// Reset empties the queue (entry count zero) and clears the response strobe;
// entry contents are never read until written.
//
// ============================================================================
`default_nettype none

module timed_command_scheduler_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output logic               busy_o,
  input  tcsq_pkg::req_t     req_i,
  output logic               done_o,
  output tcsq_pkg::rsp_t     rsp_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]        count_q, count_d;
  logic                 done_q;
  tcsq_pkg::rsp_t       rsp_q, rsp_d;
  tcsq_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 full;
  logic                 fire;

  tcsq_pkg::entry_t     entry_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stay_w;
  logic [QUEUE_DEPTH-1:0] valid_w;

  // Every operation finishes in the cycle it is taken.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(QUEUE_DEPTH));

  // The head is released when the queue holds anything and it is due.
  assign fire = (count_q != '0) && (req_i.now_time >= entry_w[0].due);

  // Decode the request word into a cell operation, the new count and the
  // response word.
  always_comb begin
    ctrl          = '0;
    ctrl.op       = tcsq_pkg::CELL_HOLD;
    count_d       = count_q;
    rsp_d         = '0;
    if (accept) begin
      case (req_i.cmd)
        tcsq_pkg::CMD_INSERT: begin
          if (!full) begin
            ctrl.op             = tcsq_pkg::CELL_PUSH;
            ctrl.fresh.code     = req_i.command_code;
            ctrl.fresh.value    = req_i.command_value;
            ctrl.fresh.due      = req_i.due_time;
            ctrl.fresh.interval = req_i.repeat_interval;
            count_d             = count_q + CW'(1);
            rsp_d.insert_accepted = 1'b1;
          end
        end
        tcsq_pkg::CMD_CLEAR: begin
          count_d               = '0;
          rsp_d.insert_accepted = 1'b1;
        end
        tcsq_pkg::CMD_TICK: begin
          if (fire) begin
            // A periodic head goes back in at due plus interval, modulo
            // 2^32; when the queue is full the copy is lost and flagged.
            ctrl.op             = tcsq_pkg::CELL_POP;
            ctrl.rearm          = (entry_w[0].interval != '0) && !full;
            ctrl.fresh          = entry_w[0];
            ctrl.fresh.due      = entry_w[0].due + entry_w[0].interval;
            rsp_d.due_valid     = 1'b1;
            rsp_d.due_command   = entry_w[0].code;
            rsp_d.due_value     = entry_w[0].value;
            rsp_d.rearm_dropped = (entry_w[0].interval != '0) && full;
            if (!ctrl.rearm) begin
              count_d = count_q - CW'(1);
            end
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
    rsp_d.entries_held = 5'(count_d);
  end

  // The row of cells. Cell 0 is the head; the ends see empty neighbors.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tcsq_pkg::entry_t left_w;
    tcsq_pkg::entry_t right_w;
    logic             stay_prev_w;
    logic             stay_next_w;

    assign valid_w[i] = (count_q > CW'(i));

    if (i == 0) begin : g_first
      assign left_w      = '0;
      assign stay_prev_w = 1'b0;
    end else begin : g_inner_l
      assign left_w      = entry_w[i-1];
      assign stay_prev_w = stay_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_w     = '0;
      assign stay_next_w = 1'b0;
    end else begin : g_inner_r
      assign right_w     = entry_w[i+1];
      assign stay_next_w = stay_w[i+1];
    end

    tcsq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid_w[i]),
      .head_i      ((i == 0) ? 1'b1 : 1'b0),
      .stay_prev_i (stay_prev_w),
      .stay_next_i (stay_next_w),
      .left_i      (left_w),
      .right_i     (right_w),
      .entry_o     (entry_w[i]),
      .stay_o      (stay_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // The response word needs no reset; it is only looked at under done_o.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The entry count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // Each accepted word gives one response in the next cycle, and only then.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing response after accepted word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("response without accepted word");

  // A lost re-arm only happens on a release from a full queue.
  a_drop_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.rearm_dropped) |-> (rsp_o.due_valid && $past(full)))
    else $error("re-arm dropped without a release from a full queue");

  // The two front entries stay in due-time order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> (entry_w[0].due <= entry_w[1].due))
    else $error("queue head out of order");

endmodule

`default_nettype wire

// ===== rtl/tcsq_cell.sv =====
// ============================================================================
// tcsq_cell : one slot of the sorted shift-register queue
// Holds one entry, compares its due time against the broadcast entry and
// takes its own, its left or its right neighbor's entry, or the new one.
// ============================================================================
`default_nettype none

module tcsq_cell (
  input  wire                   clk_i,
  input  tcsq_pkg::cell_ctrl_t  ctrl_i,
  input  wire                   valid_i,
  input  wire                   head_i,
  input  wire                   stay_prev_i,
  input  wire                   stay_next_i,
  input  tcsq_pkg::entry_t      left_i,
  input  tcsq_pkg::entry_t      right_i,
  output tcsq_pkg::entry_t      entry_o,
  output logic                  stay_o
);

  tcsq_pkg::entry_t entry_q;
  tcsq_pkg::entry_t entry_d;

  // The held entry stays ahead of the new one unless it is strictly later.
  always_comb begin
    stay_o = valid_i && !(ctrl_i.fresh.due < entry_q.due);
  end

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      tcsq_pkg::CELL_PUSH: begin
        if (!stay_o) begin
          if (head_i || stay_prev_i) begin
            entry_d = ctrl_i.fresh;
          end else begin
            entry_d = left_i;
          end
        end
      end
      tcsq_pkg::CELL_POP: begin
        // After the head leaves, this slot holds what was one to the right,
        // unless the re-armed copy lands here or further left.
        if (!ctrl_i.rearm || stay_next_i) begin
          entry_d = right_i;
        end else if (head_i || stay_o) begin
          entry_d = ctrl_i.fresh;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire
